// File: rtl/lnps_pkg.sv
// ----------------------------------------------------------------------------
// lnps_pkg
// Shared types, constants and helpers for the last-note priority stack.
// ----------------------------------------------------------------------------
package lnps_pkg;

    localparam int CHANNELS   = 2;
    localparam int NOTE_SLOTS = 129;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH      = CHANNELS * NOTE_SLOTS;
    localparam int ADDR_W     = $clog2(DEPTH);

    // sentinel slot / "no note" / "not held" marker
    localparam logic [7:0] NONE_VAL = 8'd128;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_UNUSED   = 2'd3
    } lnps_op_t;

    typedef enum logic [1:0] {
        CFG_LOW_CH0  = 2'd0,
        CFG_HIGH_CH0 = 2'd1,
        CFG_LOW_CH1  = 2'd2,
        CFG_HIGH_CH1 = 2'd3
    } lnps_cfg_idx_t;

    typedef struct packed {
        logic [7:0] prev;
        logic [7:0] next;
        logic [7:0] vel;
    } lnps_entry_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        lnps_entry_t       wdata;
    } lnps_mem_req_t;

    function automatic logic [7:0] slot_of(input logic [7:0] v);
        return (v > NONE_VAL) ? NONE_VAL : v;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                    input logic [7:0] slot);
        return ADDR_W'(ch * NOTE_SLOTS) + ADDR_W'(slot);
    endfunction

endpackage

// File: rtl/last_note_priority_stack_unit.sv
// ----------------------------------------------------------------------------
// last_note_priority_stack_unit
// Last-note priority reduction of MIDI note traffic to one mono voice per
// channel, using a doubly linked note stack per channel in a link memory.
//
//   port group  dir  handshake            payload
//   in          in   in_valid/in_ready    opcode, channel, note, velocity
//   out         out  out_valid/out_ready  current_note, current_velocity, note_held
//   cfg         in   cfg_we               cfg_idx, cfg_data
//
// One word at a time. Each link-store update is a read, then a write, of the
// link memory. in_ready rises in the cycle the result is loaded.
// After reset a sweep clears all 258 link-memory entries; in_ready stays low.
// A stalled result is held in the output register while the next word runs.
// ----------------------------------------------------------------------------
module last_note_priority_stack_unit
    import lnps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic       channel,
    input  logic [6:0] note,
    input  logic [6:0] velocity,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] current_note,
    output logic [7:0] current_velocity,
    output logic       note_held,
    input  logic       cfg_we,
    input  logic [1:0] cfg_idx,
    input  logic [6:0] cfg_data
);

    logic [6:0]    note_low_reg  [CHANNELS];
    logic [6:0]    note_high_reg [CHANNELS];
    logic          in_range;
    logic          start;
    logic          idle;
    lnps_mem_req_t req;
    lnps_entry_t   rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_low_reg[0]  <= 7'd0;
            note_high_reg[0] <= 7'd127;
            note_low_reg[1]  <= 7'd0;
            note_high_reg[1] <= 7'd127;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_LOW_CH0:  note_low_reg[0]  <= cfg_data;
                CFG_HIGH_CH0: note_high_reg[0] <= cfg_data;
                CFG_LOW_CH1:  note_low_reg[1]  <= cfg_data;
                CFG_HIGH_CH1: note_high_reg[1] <= cfg_data;
                default:      note_low_reg[0]  <= note_low_reg[0];
            endcase
        end
    end

    // low > high accepts nothing
    assign in_range = (note >= note_low_reg[channel]) && (note <= note_high_reg[channel]);
    assign in_ready = idle;
    assign start    = in_valid && idle;

    lnps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .idle      (idle),
        .op        (opcode),
        .ch        (channel),
        .note      (note),
        .vel       (velocity),
        .in_range  (in_range),
        .req       (req),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_note  (current_note),
        .out_vel   (current_velocity),
        .out_held  (note_held)
    );

    lnps_link_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    a_held_matches_note: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (note_held == (current_note != NONE_VAL)))
        else $error("note_held disagrees with current_note");

    a_held_has_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && note_held) |-> (current_velocity != NONE_VAL))
        else $error("held note reported without velocity");

    a_note_in_slots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (current_note <= NONE_VAL))
        else $error("current_note beyond sentinel slot");

    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while busy");

endmodule

// File: rtl/lnps_link_mem.sv
// ----------------------------------------------------------------------------
// lnps_link_mem
// Link store: prev/next/velocity per channel and slot. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module lnps_link_mem
    import lnps_pkg::*;
(
    input  logic          clk,
    input  lnps_mem_req_t req,
    output lnps_entry_t   rd_data
);

    lnps_entry_t mem [DEPTH];
    lnps_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lnps_ctrl.sv
// ----------------------------------------------------------------------------
// lnps_ctrl
// Sequencer: runs each word as a chain of read-modify-write steps on the
// link store, keeps the per-channel top and the output register.
// ----------------------------------------------------------------------------
module lnps_ctrl
    import lnps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            idle,
    input  logic [1:0]      op,
    input  logic [CH_W-1:0] ch,
    input  logic [6:0]      note,
    input  logic [6:0]      vel,
    input  logic            in_range,
    output lnps_mem_req_t   req,
    input  lnps_entry_t     rd_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_note,
    output logic [7:0]      out_vel,
    output logic            out_held
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ON_RD_N,
        S_ON_CHK_N,
        S_ON_RERD,
        S_ON_WR_N,
        S_ON_RD_T,
        S_ON_WR_T,
        S_OFF_RD_N,
        S_OFF_CHK_N,
        S_UL_RD_P,
        S_UL_WR_P,
        S_UL_RD_X,
        S_UL_WR_X,
        S_ALL_CHK,
        S_ALL_WR,
        S_OUT_RD,
        S_OUT_WAIT
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [6:0]        n_reg, n_next;
    logic [6:0]        vel_reg, vel_next;
    logic [7:0]        p_reg, p_next;
    logic [7:0]        x_reg, x_next;
    logic [7:0]        t_reg, t_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        top_reg [CHANNELS];
    logic [7:0]        top_next [CHANNELS];
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_note_reg, out_note_next;
    logic [7:0]        out_vel_reg, out_vel_next;
    logic              out_held_reg, out_held_next;

    logic [7:0]        t_cur;
    logic [7:0]        n_slot;
    logic              n_is_top;

    assign t_cur    = top_reg[ch_reg];
    assign n_slot   = {1'b0, n_reg};
    assign n_is_top = (n_slot == t_cur);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        n_next         = n_reg;
        vel_next       = vel_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        out_note_next  = out_note_reg;
        out_vel_next   = out_vel_reg;
        out_held_next  = out_held_reg;
        req            = '0;
        req.wdata      = rd_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = '{prev: NONE_VAL, next: NONE_VAL, vel: NONE_VAL};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    ch_next  = ch;
                    n_next   = note;
                    vel_next = vel;
                    cnt_next = '0;
                    priority if (op == OP_ALL_OFF)
                        state_next = S_ALL_CHK;
                    else if (op == OP_NOTE_ON && in_range)
                        state_next = S_ON_RD_N;
                    else if (op == OP_NOTE_OFF && in_range)
                        state_next = S_OFF_RD_N;
                    else
                        state_next = S_OUT_RD;
                end
            end
            S_ON_RD_N, S_ON_RERD:
            begin
                req.re     = 1'b1;
                req.raddr  = slot_addr(ch_reg, n_slot);
                state_next = (state_reg == S_ON_RD_N) ? S_ON_CHK_N : S_ON_WR_N;
            end
            S_ON_CHK_N, S_ON_WR_N:
            begin
                if (state_reg == S_ON_CHK_N && rd_data.vel != NONE_VAL && !n_is_top)
                begin
                    // held below the top: unlink first, then re-read
                    p_next     = slot_of(rd_data.prev);
                    x_next     = slot_of(rd_data.next);
                    state_next = S_UL_RD_P;
                end
                else
                begin
                    req.we         = 1'b1;
                    req.waddr      = slot_addr(ch_reg, n_slot);
                    req.wdata.prev = n_is_top ? rd_data.prev : t_cur;
                    req.wdata.vel  = {1'b0, vel_reg};
                    if (n_is_top)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        t_next           = t_cur;
                        top_next[ch_reg] = n_slot;
                        state_next       = S_ON_RD_T;
                    end
                end
            end
            S_ON_RD_T:
            begin
                req.re     = 1'b1;
                req.raddr  = slot_addr(ch_reg, t_reg);
                state_next = S_ON_WR_T;
            end
            S_ON_WR_T:
            begin
                req.we         = 1'b1;
                req.waddr      = slot_addr(ch_reg, t_reg);
                req.wdata.next = n_slot;
                state_next     = S_OUT_RD;
            end
            S_OFF_RD_N:
            begin
                req.re     = 1'b1;
                req.raddr  = slot_addr(ch_reg, n_slot);
                state_next = S_OFF_CHK_N;
            end
            S_OFF_CHK_N:
            begin
                if (rd_data.vel == NONE_VAL)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    req.we        = 1'b1;
                    req.waddr     = slot_addr(ch_reg, n_slot);
                    req.wdata.vel = NONE_VAL;
                    if (n_is_top)
                    begin
                        req.wdata.prev   = NONE_VAL;
                        top_next[ch_reg] = slot_of(rd_data.prev);
                        state_next       = S_OUT_RD;
                    end
                    else
                    begin
                        p_next     = slot_of(rd_data.prev);
                        x_next     = slot_of(rd_data.next);
                        state_next = S_UL_RD_P;
                    end
                end
            end
            S_UL_RD_P:
            begin
                req.re     = 1'b1;
                req.raddr  = slot_addr(ch_reg, p_reg);
                state_next = S_UL_WR_P;
            end
            S_UL_WR_P:
            begin
                req.we         = 1'b1;
                req.waddr      = slot_addr(ch_reg, p_reg);
                req.wdata.next = x_reg;
                state_next     = S_UL_RD_X;
            end
            S_UL_RD_X:
            begin
                req.re     = 1'b1;
                req.raddr  = slot_addr(ch_reg, x_reg);
                state_next = S_UL_WR_X;
            end
            S_UL_WR_X:
            begin
                req.we         = 1'b1;
                req.waddr      = slot_addr(ch_reg, x_reg);
                req.wdata.prev = p_reg;
                state_next     = (op_reg == OP_NOTE_ON) ? S_ON_RERD : S_OUT_RD;
            end
            S_ALL_CHK:
            begin
                // walk bounded to one step per slot
                if (t_cur == NONE_VAL || cnt_reg == ADDR_W'(NOTE_SLOTS))
                begin
                    top_next[ch_reg] = NONE_VAL;
                    state_next       = S_OUT_RD;
                end
                else
                begin
                    req.re     = 1'b1;
                    req.raddr  = slot_addr(ch_reg, t_cur);
                    state_next = S_ALL_WR;
                end
            end
            S_ALL_WR:
            begin
                req.we           = 1'b1;
                req.waddr        = slot_addr(ch_reg, t_cur);
                req.wdata.vel    = NONE_VAL;
                top_next[ch_reg] = slot_of(rd_data.prev);
                cnt_next         = cnt_reg + 1'b1;
                state_next       = S_ALL_CHK;
            end
            S_OUT_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = slot_addr(ch_reg, t_cur);
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_note_next  = t_cur;
                    out_vel_next   = rd_data.vel;
                    out_held_next  = (t_cur != NONE_VAL);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                top_reg[i] <= NONE_VAL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ch_reg        <= ch_next;
            n_reg         <= n_next;
            vel_reg       <= vel_next;
            p_reg         <= p_next;
            x_reg         <= x_next;
            t_reg         <= t_next;
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            out_note_reg  <= out_note_next;
            out_vel_reg   <= out_vel_next;
            out_held_reg  <= out_held_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_note  = out_note_reg;
    assign out_vel   = out_vel_reg;
    assign out_held  = out_held_reg;

endmodule

// File: tb/tb_last_note_priority_stack_unit.sv
// ----------------------------------------------------------------------------
// tb_last_note_priority_stack_unit
// Self-checking bench for the last-note priority stack. A short table of
// directed words is followed by random note traffic over several note-range
// settings. Every word is run through a local model of the per-channel note
// stacks; each result word is compared in order against the model, or against
// the fixed result of a table row that gives one. Both handshakes idle at
// random, and the result side holds off for a long stretch once so the block backs up.
// ----------------------------------------------------------------------------
module tb_last_note_priority_stack_unit;
    import lnps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_WORDS  = 172;
    localparam int SETTLE       = 40;
    localparam int BACKUP_AT    = 300;
    localparam int BACKUP_LEN   = 400;

    typedef struct packed {
        logic [7:0] top_note;
        logic [7:0] top_vel;
        logic       held;
    } voice_word_t;

    typedef struct packed {
        lnps_op_t    op;
        logic        ch;
        logic [6:0]  n;
        logic [6:0]  v;
        logic        fixed;
        voice_word_t res;
    } dir_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       opcode = '0;
    logic             channel = 1'b0;
    logic [6:0]       note = '0;
    logic [6:0]       velocity = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       current_note;
    logic [7:0]       current_velocity;
    logic             note_held;
    logic             cfg_we = 1'b0;
    lnps_cfg_idx_t    cfg_idx = CFG_LOW_CH0;
    logic [6:0]       cfg_data = '0;

    // model of the note stacks and the range registers
    logic [7:0]       voice_prev [CHANNELS][NOTE_SLOTS];
    logic [7:0]       voice_next [CHANNELS][NOTE_SLOTS];
    logic [7:0]       voice_vel  [CHANNELS][NOTE_SLOTS];
    logic [7:0]       voice_top  [CHANNELS];
    logic [6:0]       range_lo   [CHANNELS];
    logic [6:0]       range_hi   [CHANNELS];

    voice_word_t      voice_expect_q [$];
    int               err_count = 0;
    int               results_seen = 0;
    int               cycle_count = 0;
    int               tx_gap = 0;
    logic             tx_idle = 1'b1;
    logic             rx_idle = 1'b1;
    int               pool_base [CHANNELS];
    int               pool_w    [CHANNELS];

    dir_row_t dir_table [22] = '{
        '{OP_NOTE_OFF, 1'b0, 7'd60,  7'd0,   1'b1, '{8'd128, 8'd128, 1'b0}},
        '{OP_ALL_OFF,  1'b1, 7'd0,   7'd0,   1'b1, '{8'd128, 8'd128, 1'b0}},
        '{OP_UNUSED,   1'b0, 7'd5,   7'd5,   1'b1, '{8'd128, 8'd128, 1'b0}},
        '{OP_NOTE_ON,  1'b0, 7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   1'b1}},
        '{OP_NOTE_ON,  1'b0, 7'd127, 7'd127, 1'b1, '{8'd127, 8'd127, 1'b1}},
        '{OP_NOTE_ON,  1'b1, 7'd64,  7'd100, 1'b1, '{8'd64,  8'd100, 1'b1}},
        '{OP_NOTE_ON,  1'b0, 7'd127, 7'd1,   1'b1, '{8'd127, 8'd1,   1'b1}},
        '{OP_NOTE_ON,  1'b0, 7'd60,  7'd64,  1'b1, '{8'd60,  8'd64,  1'b1}},
        '{OP_NOTE_ON,  1'b0, 7'd0,   7'd99,  1'b1, '{8'd0,   8'd99,  1'b1}},
        '{OP_NOTE_OFF, 1'b0, 7'd127, 7'd0,   1'b0, '0},
        '{OP_NOTE_OFF, 1'b0, 7'd0,   7'd0,   1'b0, '0},
        '{OP_NOTE_OFF, 1'b0, 7'd5,   7'd0,   1'b0, '0},
        '{OP_UNUSED,   1'b1, 7'd127, 7'd127, 1'b0, '0},
        '{OP_NOTE_ON,  1'b0, 7'd85,  7'd42,  1'b0, '0},
        '{OP_NOTE_ON,  1'b0, 7'd42,  7'd85,  1'b0, '0},
        '{OP_ALL_OFF,  1'b0, 7'd0,   7'd0,   1'b1, '{8'd128, 8'd128, 1'b0}},
        '{OP_NOTE_OFF, 1'b0, 7'd60,  7'd0,   1'b1, '{8'd128, 8'd128, 1'b0}},
        '{OP_NOTE_ON,  1'b1, 7'd127, 7'd127, 1'b0, '0},
        '{OP_NOTE_OFF, 1'b1, 7'd64,  7'd0,   1'b0, '0},
        '{OP_ALL_OFF,  1'b1, 7'd0,   7'd0,   1'b1, '{8'd128, 8'd128, 1'b0}},
        '{OP_NOTE_ON,  1'b1, 7'd1,   7'd127, 1'b1, '{8'd1,   8'd127, 1'b1}},
        '{OP_NOTE_OFF, 1'b1, 7'd1,   7'd0,   1'b1, '{8'd128, 8'd128, 1'b0}}
    };

    last_note_priority_stack_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .channel          (channel),
        .note             (note),
        .velocity         (velocity),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .current_note     (current_note),
        .current_velocity (current_velocity),
        .note_held        (note_held),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // links past the sentinel fall back to the sentinel
    function automatic logic [7:0] clamp_slot(input logic [7:0] s);
        return (s > NONE_VAL) ? NONE_VAL : s;
    endfunction

    function automatic void unlink_slot(input logic ch, input logic [7:0] s);
        logic [7:0] p;
        logic [7:0] x;
        p = clamp_slot(voice_prev[ch][s]);
        x = clamp_slot(voice_next[ch][s]);
        voice_next[ch][p] = x;
        voice_prev[ch][x] = p;
    endfunction

    function automatic voice_word_t predict_voice(input lnps_op_t op, input logic ch,
                                                 input logic [6:0] n, input logic [6:0] v);
        logic [7:0]  t;
        logic [7:0]  s;
        voice_word_t r;
        s = {1'b0, n};
        if (op == OP_ALL_OFF)
        begin
            for (int k = 0; k < NOTE_SLOTS; k++)
            begin
                t = clamp_slot(voice_top[ch]);
                if (t == NONE_VAL)
                    break;
                voice_vel[ch][t] = NONE_VAL;
                voice_top[ch] = clamp_slot(voice_prev[ch][t]);
            end
            voice_top[ch] = NONE_VAL;
        end
        else if ((op == OP_NOTE_ON || op == OP_NOTE_OFF)
                 && n >= range_lo[ch] && n <= range_hi[ch])
        begin
            t = clamp_slot(voice_top[ch]);
            if (op == OP_NOTE_ON)
            begin
                if (voice_vel[ch][s] != NONE_VAL && s != t)
                    unlink_slot(ch, s);
                voice_vel[ch][s] = {1'b0, v};
                if (s != t)
                begin
                    voice_next[ch][t] = s;
                    voice_prev[ch][s] = t;
                    voice_top[ch] = s;
                end
            end
            else if (voice_vel[ch][s] != NONE_VAL)
            begin
                voice_vel[ch][s] = NONE_VAL;
                if (s == t)
                begin
                    voice_top[ch] = clamp_slot(voice_prev[ch][s]);
                    voice_prev[ch][s] = NONE_VAL;
                end
                else
                    unlink_slot(ch, s);
            end
        end
        t = clamp_slot(voice_top[ch]);
        r.top_note = t;
        r.top_vel  = voice_vel[ch][t];
        r.held     = (t != NONE_VAL);
        return r;
    endfunction

    task automatic send_word(input lnps_op_t op, input logic ch, input logic [6:0] n,
                             input logic [6:0] v, input logic fixed,
                             input voice_word_t fixed_res);
        logic        took;
        voice_word_t res;
        if (tx_gap > 0)
            repeat (tx_gap) @(posedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        channel  <= ch;
        note     <= n;
        velocity <= v;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        res = predict_voice(op, ch, n, v);
        voice_expect_q.push_back(fixed ? fixed_res : res);
        tx_gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (tx_gap > 0)
            in_valid <= 1'b0;
    endtask

    // stop offering, wait for every result, then let the block go quiet
    task automatic drain_words();
        if (tx_gap == 0)
            in_valid <= 1'b0;
        tx_gap = 1;
        while (voice_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input lnps_cfg_idx_t idx, input logic [6:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LOW_CH0:  range_lo[0] = val;
            CFG_HIGH_CH0: range_hi[0] = val;
            CFG_LOW_CH1:  range_lo[1] = val;
            CFG_HIGH_CH1: range_hi[1] = val;
        endcase
    endtask

    task automatic set_ranges(input logic [6:0] lo0, input logic [6:0] hi0,
                              input logic [6:0] lo1, input logic [6:0] hi1);
        write_reg(CFG_LOW_CH0, lo0);
        write_reg(CFG_HIGH_CH0, hi0);
        write_reg(CFG_LOW_CH1, lo1);
        write_reg(CFG_HIGH_CH1, hi1);
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    task automatic run_random_phase(input int count);
        lnps_op_t    op;
        logic        ch;
        logic [6:0]  n;
        int          r;
        int          pick;
        // notes cluster in a small window per channel so that note-offs hit held notes
        for (int c = 0; c < CHANNELS; c++)
        begin
            pool_w[c] = $urandom_range(4, 48);
            if (range_lo[c] <= range_hi[c])
                pool_base[c] = int'($urandom_range(range_lo[c], range_hi[c])) - pool_w[c] / 2;
            else
                pool_base[c] = $urandom_range(0, 127);
            if (pool_base[c] < 0)
                pool_base[c] = 0;
        end
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                tx_idle = ($urandom_range(0, 2) != 0);
            ch = 1'($urandom_range(0, 1));
            r  = $urandom_range(0, 99);
            if (r < 55)
                op = OP_NOTE_ON;
            else if (r < 94)
                op = OP_NOTE_OFF;
            else if (r < 98)
                op = OP_ALL_OFF;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 9) < 8)
            begin
                pick = pool_base[ch] + $urandom_range(0, pool_w[ch] - 1);
                n = (pick > 127) ? 7'd127 : pick[6:0];
            end
            else
                n = 7'($urandom_range(0, 127));
            send_word(op, ch, n, 7'($urandom_range(0, 127)), 1'b0, '0);
        end
    endtask

    initial
    begin : result_sink
        int          hold;
        logic        got;
        voice_word_t seen;
        voice_word_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (results_seen == BACKUP_AT)
                hold = BACKUP_LEN;
            else
                hold = rx_idle ? $urandom_range(0, 9) : 0;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = out_valid;
                seen.top_note = current_note;
                seen.top_vel  = current_velocity;
                seen.held     = note_held;
                @(posedge clk);
            end
            while (!got);
            results_seen++;
            if (results_seen % 40 == 0)
                rx_idle = ($urandom_range(0, 2) != 0);
            if (voice_expect_q.size() == 0)
            begin
                $error("result word with nothing expected: note %0d vel %0d held %0d",
                       seen.top_note, seen.top_vel, seen.held);
                err_count++;
            end
            else
            begin
                want = voice_expect_q.pop_front();
                if (seen.top_note !== want.top_note)
                begin
                    $error("current_note: expected %0d, got %0d", want.top_note, seen.top_note);
                    err_count++;
                end
                if (seen.top_vel !== want.top_vel)
                begin
                    $error("current_velocity: expected %0d, got %0d",
                           want.top_vel, seen.top_vel);
                    err_count++;
                end
                if (seen.held !== want.held)
                begin
                    $error("note_held: expected %0d, got %0d", want.held, seen.held);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [6:0] lo;
        logic [6:0] hi;
        logic [6:0] lo1;
        logic [6:0] hi1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            voice_top[c] = NONE_VAL;
            range_lo[c]  = 7'd0;
            range_hi[c]  = 7'd127;
            for (int s = 0; s < NOTE_SLOTS; s++)
            begin
                voice_prev[c][s] = NONE_VAL;
                voice_next[c][s] = NONE_VAL;
                voice_vel[c][s]  = NONE_VAL;
            end
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            send_word(dir_table[i].op, dir_table[i].ch, dir_table[i].n, dir_table[i].v,
                      dir_table[i].fixed, dir_table[i].res);
        drain_words();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: ;
                1: set_ranges(7'd20, 7'd100, 7'd0, 7'd0);
                // channel one empty range; notes held from before stay until all-off
                2: set_ranges(7'd127, 7'd127, 7'd100, 7'd30);
                3: set_ranges(7'd0, 7'd127, 7'd0, 7'd127);
                default:
                begin
                    lo  = 7'($urandom_range(0, 127));
                    hi  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(lo, 127));
                    lo1 = 7'($urandom_range(0, 127));
                    hi1 = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(lo1, 127));
                    set_ranges(lo, hi, lo1, hi1);
                end
            endcase
            run_random_phase(PHASE_WORDS);
            drain_words();
        end

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
